### rtl/conv3x3_window_filter_defines.svh
// Assertion macros for the 3x3 window filter.
// Each macro expects i_clk and i_rst_n in scope and is disabled during reset.
`ifndef CONV3X3_WINDOW_FILTER_DEFINES_SVH
`define CONV3X3_WINDOW_FILTER_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define CWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cwf_pkg.sv
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared widths, register indexes, pipeline types and the kernel coefficient
// extraction for the 3x3 window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwf_pkg;

    localparam int PIX_W        = 8;
    localparam int COEF_W       = 16;
    localparam int KROW_W       = 3 * COEF_W;
    localparam int SIZE_W       = 12;
    localparam int POS_W        = 11;
    localparam int PROD_W       = COEF_W + PIX_W + 1;
    localparam int RSUM_W       = PROD_W + 2;
    localparam int SUM_W        = 28;
    localparam int OUT_DATA_W   = 56;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_SIZE_DEF = 2048;
    localparam int SIZE_MIN     = 3;

    // Result queue depth and the number of stages between accept and queue write.
    localparam int FIFO_DEPTH   = 8;
    localparam int PIPE_DEPTH   = 4;

    localparam logic [KROW_W-1:0] KERNEL_RESET = 48'h071C_071C_071C;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 12'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROW_TOP    = 2'd0,
        CFG_KROW_MIDDLE = 2'd1,
        CFG_KROW_BOTTOM = 2'd2,
        CFG_IMAGE_SIZE  = 2'd3
    } t_cfg_index;

    // Position and emit information that follows a pixel down the pipeline.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    // New right-hand window column: top is two rows up, bot is the incoming pixel.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [SUM_W-1:0] sum;
    } t_result;

    // Coefficient j of a kernel row: left in the low bits.
    function automatic logic signed [COEF_W-1:0] coef(input logic [KROW_W-1:0] krow,
                                                      input int unsigned j);
        logic [COEF_W-1:0] v;
        v = krow[j*COEF_W +: COEF_W];
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

### rtl/cwf_line_store.sv
// ----------------------------------------------------------------------------
// cwf_line_store
// Two line memories holding the previous row and the row before it. Each
// accepted pixel reads its column, and in the following cycle writes the
// shifted column back; a back-to-back request to the same column is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_line_store
    import cwf_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int ADDR_W   = $clog2(MAX_SIZE)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [PIX_W-1:0]  i_px,
    input  wire t_tag              i_tag,
    output logic                   o_valid,
    output t_col                   o_col,
    output t_tag                   o_tag
);

    logic [PIX_W-1:0]  r_mem0 [MAX_SIZE];
    logic [PIX_W-1:0]  r_mem1 [MAX_SIZE];
    logic [PIX_W-1:0]  r_dout0;
    logic [PIX_W-1:0]  r_dout1;

    logic              r_b_valid;
    logic [ADDR_W-1:0] r_b_addr;
    logic [PIX_W-1:0]  r_b_px;
    t_tag              r_b_tag;
    logic              r_fwd;
    logic [PIX_W-1:0]  r_fwd_px;
    logic [PIX_W-1:0]  r_fwd_d0;

    logic [PIX_W-1:0]  d0;
    logic [PIX_W-1:0]  d1;

    // Take the pending write's values when the read raced it.
    assign d0 = r_fwd ? r_fwd_px : r_dout0;
    assign d1 = r_fwd ? r_fwd_d0 : r_dout1;

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_dout0 <= r_mem0[i_addr];
            r_dout1 <= r_mem1[i_addr];
        end
        if (r_b_valid) begin
            r_mem0[r_b_addr] <= r_b_px;
            r_mem1[r_b_addr] <= d0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_b_valid <= i_req;
            r_fwd     <= i_req && r_b_valid && (r_b_addr == i_addr);
        end
        r_b_addr <= i_addr;
        r_b_px   <= i_px;
        r_b_tag  <= i_tag;
        r_fwd_px <= r_b_px;
        r_fwd_d0 <= d0;
    end

    assign o_valid   = r_b_valid;
    assign o_col.top = d1;
    assign o_col.mid = d0;
    assign o_col.bot = r_b_px;
    assign o_tag     = r_b_tag;

endmodule

`default_nettype wire

### rtl/cwf_mac.sv
// ----------------------------------------------------------------------------
// cwf_mac
// 3x3 window register, nine coefficient products, row sums and the final
// sum. Only pixels marked to emit travel past the window stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_mac
    import cwf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire t_col                    i_col,
    input  wire t_tag                    i_tag,
    input  wire logic [2:0][KROW_W-1:0]  i_krow,
    output logic                         o_valid,
    output t_result                      o_result
);

    logic [PIX_W-1:0]         r_win [3][3];
    logic                     r_w_valid;
    t_tag                     r_w_tag;

    logic signed [PROD_W-1:0] r_prod [3][3];
    logic                     r_p_valid;
    t_tag                     r_p_tag;

    logic signed [RSUM_W-1:0] r_rsum [3];
    logic                     r_s_valid;
    t_tag                     r_s_tag;

    // Shift the window left on every pixel; the new column enters on the right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_col.top;
            r_win[1][2] <= i_col.mid;
            r_win[2][2] <= i_col.bot;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= coef(i_krow[i], j) * $signed({1'b0, r_win[i][j]});
            end
            r_rsum[i] <= RSUM_W'(r_prod[i][0]) + RSUM_W'(r_prod[i][1])
                       + RSUM_W'(r_prod[i][2]);
        end
        r_w_tag <= i_tag;
        r_p_tag <= r_w_tag;
        r_s_tag <= r_p_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_w_valid <= i_valid && i_tag.emit;
            r_p_valid <= r_w_valid;
            r_s_valid <= r_p_valid;
        end
    end

    assign o_valid      = r_s_valid;
    assign o_result.sum = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
    assign o_result.row = r_s_tag.row;
    assign o_result.col = r_s_tag.col;
    assign o_result.last = r_s_tag.last;

endmodule

`default_nettype wire

### rtl/cwf_out_fifo.sv
// ----------------------------------------------------------------------------
// cwf_out_fifo
// Small result queue that decouples the filter pipeline from the output
// handshake. Its fill level drives the input-side credit check.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_out_fifo
    import cwf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire t_result i_data,
    input  wire logic    i_rd,
    output logic         o_valid,
    output t_result      o_data,
    output logic [CW-1:0] o_count
);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign pop = i_rd && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

### rtl/conv3x3_window_filter.sv
// Result path: the request of the pixel that completes a window passes the line memory
//   read, window, products, row sums and queue stages before its result is offered.
// Throughput: one pixel per cycle, set by the single read and write port of each
//   line memory; input stalls only when the result queue backs up.
// Reset (synchronous, active low): position to row 0 column 0, window to zero,
//   kernel to 1820 per coefficient, image size 512; line memories are not cleared.
// ----------------------------------------------------------------------------
// conv3x3_window_filter
// 3x3 convolution over a square raster-order 8-bit image with a programmable
// signed Q1.14 kernel, emitting one full-precision result per interior pixel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "conv3x3_window_filter_defines.svh"

module conv3x3_window_filter
    import cwf_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [PIX_W-1:0]      i_s_axis_tdata,   // [7:0] pixel
    input  wire logic                  i_s_axis_tuser,   // [0] frame_start
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [27:0] weighted_sum, [38:28] out_row, [49:39] out_col, [55:50] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [KROW_W-1:0]     i_cfg_data
);

    localparam int CW   = $clog2(MAX_SIZE + 1);
    localparam int AW   = $clog2(MAX_SIZE);
    localparam int EW   = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);

    logic [2:0][KROW_W-1:0] r_krow;
    logic [SIZE_W-1:0]      r_size;
    logic [CW-1:0]          r_row;
    logic [CW-1:0]          r_col;
    logic [CW-1:0]          n_row;
    logic [CW-1:0]          n_col;

    logic [EW-1:0]          size_ext;
    logic [CW-1:0]          s_eff;
    logic [CW-1:0]          row0;
    logic [CW-1:0]          col0;
    logic [CW-1:0]          row1;
    logic                   accept;
    t_tag                   tag;

    logic                   ls_valid;
    t_col                   ls_col;
    t_tag                   ls_tag;
    logic                   mac_valid;
    t_result                mac_result;
    logic                   fifo_valid;
    t_result                fifo_data;
    logic [FCW-1:0]         fifo_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow[0] <= KERNEL_RESET;
            r_krow[1] <= KERNEL_RESET;
            r_krow[2] <= KERNEL_RESET;
            r_size    <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_KROW_TOP:    r_krow[0] <= i_cfg_data;
                CFG_KROW_MIDDLE: r_krow[1] <= i_cfg_data;
                CFG_KROW_BOTTOM: r_krow[2] <= i_cfg_data;
                CFG_IMAGE_SIZE:  r_size    <= i_cfg_data[SIZE_W-1:0];
                default:         r_size    <= r_size;
            endcase
        end
    end

    // Clamp the programmed size to the supported range.
    always_comb begin
        size_ext = EW'(r_size);
        if (size_ext < EW'(SIZE_MIN)) begin
            s_eff = CW'(SIZE_MIN);
        end else if (size_ext > EW'(MAX_SIZE)) begin
            s_eff = CW'(MAX_SIZE);
        end else begin
            s_eff = CW'(size_ext);
        end
    end

    // Position of the incoming pixel: restart on frame start, wrap at the edges.
    always_comb begin
        row0 = i_s_axis_tuser ? '0 : r_row;
        col0 = i_s_axis_tuser ? '0 : r_col;
        if (col0 >= s_eff) begin
            n_col = '0;
            row1  = row0 + 1'b1;
        end else begin
            n_col = col0;
            row1  = row0;
        end
        n_row = (row1 >= s_eff) ? '0 : row1;

        tag.emit = (n_row >= CW'(2)) && (n_col >= CW'(2));
        tag.last = (n_row == s_eff - 1'b1) && (n_col == s_eff - 1'b1);
        tag.row  = POS_W'(n_row - 1'b1);
        tag.col  = POS_W'(n_col - 1'b1);
    end

    assign o_s_axis_tready = (fifo_count <= FCW'(FIFO_DEPTH - 1 - PIPE_DEPTH));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col + 1'b1;
        end
    end

    cwf_line_store #(
        .MAX_SIZE (MAX_SIZE),
        .ADDR_W   (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (accept),
        .i_addr  (n_col[AW-1:0]),
        .i_px    (i_s_axis_tdata),
        .i_tag   (tag),
        .o_valid (ls_valid),
        .o_col   (ls_col),
        .o_tag   (ls_tag)
    );

    cwf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ls_valid),
        .i_col    (ls_col),
        .i_tag    (ls_tag),
        .i_krow   (r_krow),
        .o_valid  (mac_valid),
        .o_result (mac_result)
    );

    cwf_out_fifo #(
        .DEPTH (FIFO_DEPTH),
        .AW    ($clog2(FIFO_DEPTH)),
        .CW    (FCW)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mac_valid),
        .i_data  (mac_result),
        .i_rd    (i_m_axis_tready),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_m_axis_tvalid = fifo_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({fifo_data.col, fifo_data.row, fifo_data.sum});
    assign o_m_axis_tlast  = fifo_data.last;

    `CWF_ASSERT_NOW(a_fifo_no_overflow, mac_valid && !(i_m_axis_tready && fifo_valid),
        fifo_count < FCW'(FIFO_DEPTH), "result queue overflow")
    `CWF_ASSERT_NEXT(a_col_advances, accept, r_col != '0,
        "column count did not advance after a request")
    `CWF_ASSERT_NOW(a_last_on_diagonal, mac_valid && mac_result.last,
        mac_result.row == mac_result.col, "frame end marked off the final pixel")

endmodule

`default_nettype wire
